>>> rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants for the desk drive supervisor.
// ----------------------------------------------------------------------------
package dds_pkg;

   // event codes on the request channel
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_UP   = 2'd1;
   localparam logic [1:0] CMD_DOWN = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;

   // drive direction codes
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_UP   = 2'd2;

   // limit update codes
   localparam logic [1:0] UPD_NONE  = 2'd0;
   localparam logic [1:0] UPD_UPPER = 2'd1;
   localparam logic [1:0] UPD_LOWER = 2'd2;

   // stop cause codes
   localparam logic [1:0] STOP_NONE  = 2'd0;
   localparam logic [1:0] STOP_LIMIT = 2'd1;
   localparam logic [1:0] STOP_STALL = 2'd2;

   // register indexes
   localparam logic [7:0] CSR_STARTUP_DELAY  = 8'd0;
   localparam logic [7:0] CSR_CHECK_INTERVAL = 8'd1;
   localparam logic [7:0] CSR_DOUBLE_CLICK   = 8'd2;

   localparam logic [7:0] HEIGHT_MIN = 8'd65;
   localparam logic [7:0] HEIGHT_MAX = 8'd130;
   localparam logic [7:0] HEIGHT_RST = 8'd90;
   localparam logic [7:0] UPPER_RST  = 8'd115;
   localparam logic [7:0] LOWER_RST  = 8'd78;

   localparam logic [15:0] STARTUP_DELAY_RST  = 16'd2000;
   localparam logic [15:0] CHECK_INTERVAL_RST = 16'd300;
   localparam logic [15:0] DOUBLE_CLICK_RST   = 16'd500;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] value;
   } item_type;

   typedef struct packed {
      logic       drive_up;
      logic       drive_down;
      logic       led;
      logic [1:0] direction;
      logic [7:0] height;
      logic [7:0] upper_limit_out;
      logic [7:0] lower_limit_out;
      logic [1:0] limit_update;
      logic [1:0] stop_cause;
   } result_type;

   typedef struct packed {
      logic        wr;
      logic [7:0]  index;
      logic [15:0] data;
   } csr_wr_type;

endpackage

>>> rtl/dds_if.sv
// ----------------------------------------------------------------------------
// dds_if
// Valid/ready channel interfaces for the desk drive supervisor.
// ----------------------------------------------------------------------------
interface dds_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] value;

   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

interface dds_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_up;
   logic       drive_down;
   logic       led;
   logic [1:0] direction;
   logic [7:0] height;
   logic [7:0] upper_limit_out;
   logic [7:0] lower_limit_out;
   logic [1:0] limit_update;
   logic [1:0] stop_cause;

   modport source (output valid, drive_up, drive_down, led, direction, height,
                   upper_limit_out, lower_limit_out, limit_update, stop_cause,
                   input ready);
   modport sink   (input valid, drive_up, drive_down, led, direction, height,
                   upper_limit_out, lower_limit_out, limit_update, stop_cause,
                   output ready);
endinterface

interface dds_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/dds_in_reg.sv
// ----------------------------------------------------------------------------
// dds_in_reg
// Input register: captures one event, hands it on when the result stage
// can take a new transaction.
// ----------------------------------------------------------------------------
module dds_in_reg
   import dds_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     down_ready,
   output logic     fire,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign fire     = valid_ff && down_ready;
   assign in_ready = !valid_ff || down_ready;
   assign item     = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

>>> rtl/dds_core.sv
// ----------------------------------------------------------------------------
// dds_core
// Supervisor state and next-state logic: frame decode, button handling,
// limit and stall checks. State advances once per fired transaction.
// ----------------------------------------------------------------------------
module dds_core
   import dds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  csr_wr_type csr_wr,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   // configuration
   logic [15:0] startup_delay_ff;
   logic [15:0] check_interval_ff;
   logic [15:0] double_click_ff;

   // state; time stamps are kept as elapsed-tick counters
   logic [7:0]  fw0_ff, fw0_in;
   logic [7:0]  fw1_ff, fw1_in;
   logic [7:0]  height_ff, height_in;
   logic [1:0]  dir_ff, dir_in;
   logic        wait_ff, wait_in;
   logic [31:0] since_start_ff, since_start_in;
   logic [31:0] since_check_ff, since_check_in;
   logic [31:0] since_rel_ff, since_rel_in;
   logic [7:0]  last_h_ff, last_h_in;
   logic        up_held_ff, up_held_in;
   logic        dn_held_ff, dn_held_in;
   logic [7:0]  upper_ff, upper_in;
   logic [7:0]  lower_ff, lower_in;
   logic        led_ff, led_in;

   logic [31:0] tick_inc;
   logic [31:0] start_cnt, check_cnt, rel_cnt;
   logic [31:0] start_v;
   logic [7:0]  last_h_v;
   logic [7:0]  mid;
   logic        btn_high, self_held, other_held, self_next;
   logic [1:0]  upd;
   logic [1:0]  cause;

   assign tick_inc  = {31'd0, item.cmd == CMD_TICK};
   assign start_cnt = since_start_ff + tick_inc;
   assign check_cnt = since_check_ff + tick_inc;
   assign rel_cnt   = since_rel_ff + tick_inc;
   assign mid       = 8'(({1'b0, upper_ff} + {1'b0, lower_ff}) >> 1);
   assign btn_high  = item.value != 8'd0;
   assign self_held  = (item.cmd == CMD_UP) ? up_held_ff : dn_held_ff;
   assign other_held = (item.cmd == CMD_UP) ? dn_held_ff : up_held_ff;

   always_comb begin
      fw0_in         = fw0_ff;
      fw1_in         = fw1_ff;
      height_in      = height_ff;
      dir_in         = dir_ff;
      wait_in        = wait_ff;
      since_start_in = start_cnt;
      since_check_in = check_cnt;
      since_rel_in   = rel_cnt;
      last_h_in      = last_h_ff;
      up_held_in     = up_held_ff;
      dn_held_in     = dn_held_ff;
      upper_in       = upper_ff;
      lower_in       = lower_ff;
      led_in         = led_ff;
      upd            = UPD_NONE;
      cause          = STOP_NONE;
      self_next      = self_held;
      start_v        = start_cnt;
      last_h_v       = last_h_ff;

      // event handling
      case (item.cmd)
         CMD_BYTE: begin
            if (fw0_ff == 8'd1 && fw1_ff == 8'd0 &&
                item.value >= HEIGHT_MIN && item.value <= HEIGHT_MAX) begin
               height_in = item.value;
            end
            fw0_in = fw1_ff;
            fw1_in = item.value;
         end
         CMD_UP, CMD_DOWN: begin
            if (dir_ff == DIR_STOP) begin
               if (btn_high && !self_held) begin
                  // press; both held stores a limit and drops this press
                  self_next = !other_held;
                  led_in    = 1'b0;
                  if (other_held) begin
                     if (height_ff >= mid) begin
                        upper_in = height_ff;
                        upd      = UPD_UPPER;
                     end else begin
                        lower_in = height_ff;
                        upd      = UPD_LOWER;
                     end
                  end
               end else if (!btn_high && self_held) begin
                  self_next = 1'b0;
                  if (rel_cnt[31:16] == 16'd0 && rel_cnt[15:0] < double_click_ff) begin
                     dir_in = (item.cmd == CMD_UP) ? DIR_UP : DIR_DOWN;
                  end else begin
                     since_rel_in = 32'd0;
                  end
               end
               if (item.cmd == CMD_UP) begin
                  up_held_in = self_next;
               end else begin
                  dn_held_in = self_next;
               end
            end
         end
         default: begin
         end
      endcase

      // supervisor pass on the updated state
      if (dir_in == DIR_UP && ({1'b0, height_in} + 9'd1) >= {1'b0, upper_in}) begin
         dir_in  = DIR_STOP;
         wait_in = 1'b0;
         cause   = STOP_LIMIT;
      end else if (dir_in == DIR_DOWN &&
                   {1'b0, height_in} <= ({1'b0, lower_in} + 9'd1)) begin
         dir_in  = DIR_STOP;
         wait_in = 1'b0;
         cause   = STOP_LIMIT;
      end else if (dir_in != DIR_STOP) begin
         if (!wait_ff) begin
            start_v  = 32'd0;
            last_h_v = (dir_in == DIR_DOWN) ? HEIGHT_MAX : 8'd0;
         end
         wait_in        = 1'b1;
         since_start_in = start_v;
         last_h_in      = last_h_v;
         if (start_v >= {16'd0, startup_delay_ff} &&
             check_cnt >= {16'd0, check_interval_ff}) begin
            since_check_in = 32'd0;
            last_h_in      = height_in;
            if ((height_in >= last_h_v && dir_in == DIR_DOWN) ||
                (height_in <= last_h_v && dir_in == DIR_UP)) begin
               led_in  = 1'b1;
               dir_in  = DIR_STOP;
               wait_in = 1'b0;
               cause   = STOP_STALL;
            end
         end
      end
   end

   always_comb begin
      result.drive_up        = dir_in == DIR_UP;
      result.drive_down      = dir_in == DIR_DOWN;
      result.led             = led_in;
      result.direction       = dir_in;
      result.height          = height_in;
      result.upper_limit_out = upper_in;
      result.lower_limit_out = lower_in;
      result.limit_update    = upd;
      result.stop_cause      = cause;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_delay_ff  <= STARTUP_DELAY_RST;
         check_interval_ff <= CHECK_INTERVAL_RST;
         double_click_ff   <= DOUBLE_CLICK_RST;
      end else if (csr_wr.wr) begin
         case (csr_wr.index)
            CSR_STARTUP_DELAY:  startup_delay_ff  <= csr_wr.data;
            CSR_CHECK_INTERVAL: check_interval_ff <= csr_wr.data;
            CSR_DOUBLE_CLICK:   double_click_ff   <= csr_wr.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw0_ff         <= 8'd0;
         fw1_ff         <= 8'd0;
         height_ff      <= HEIGHT_RST;
         dir_ff         <= DIR_STOP;
         wait_ff        <= 1'b0;
         since_start_ff <= 32'd0;
         since_check_ff <= 32'd0;
         since_rel_ff   <= 32'd0;
         last_h_ff      <= 8'd0;
         up_held_ff     <= 1'b0;
         dn_held_ff     <= 1'b0;
         upper_ff       <= UPPER_RST;
         lower_ff       <= LOWER_RST;
         led_ff         <= 1'b0;
      end else if (fire) begin
         fw0_ff         <= fw0_in;
         fw1_ff         <= fw1_in;
         height_ff      <= height_in;
         dir_ff         <= dir_in;
         wait_ff        <= wait_in;
         since_start_ff <= since_start_in;
         since_check_ff <= since_check_in;
         since_rel_ff   <= since_rel_in;
         last_h_ff      <= last_h_in;
         up_held_ff     <= up_held_in;
         dn_held_ff     <= dn_held_in;
         upper_ff       <= upper_in;
         lower_ff       <= lower_in;
         led_ff         <= led_in;
      end
   end

endmodule

>>> rtl/dds_out_reg.sv
// ----------------------------------------------------------------------------
// dds_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module dds_out_reg
   import dds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

>>> rtl/desk_drive_supervisor.sv
// ----------------------------------------------------------------------------
// desk_drive_supervisor
// Motor supervisor for a height-adjustable desk.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one event per transaction: a serial byte, an up or down
//   button level, or a millisecond tick. rsp_chan returns exactly one result
//   per event: motor lines, stall LED, direction, height, both limits, a
//   limit-update code and a stop cause. csr_chan writes the startup delay,
//   check interval and double-click window; it is always ready. The user
//   must write it only while no event is in flight; the block itself
//   does not enforce this. A request is captured in the input register;
//   the supervisor logic then evaluates and updates its state as the
//   result is loaded into the output register, once that register can
//   take it, and there it shows valid. Throughput is one event per cycle
//   while the receiver keeps taking results; the state is registered as
//   each event fires, so back-to-back events see each other's effects.
//   Reset (synchronous) restores the default limits, height and timings and
//   empties both registers. When the receiver stalls, the output register
//   holds its result and the input register takes one more event before
//   req_chan.ready drops.
// ----------------------------------------------------------------------------
module desk_drive_supervisor
   import dds_pkg::*;
(
   input logic       clock,
   input logic       reset,
   dds_req_if.sink   req_chan,
   dds_rsp_if.source rsp_chan,
   dds_csr_if.sink   csr_chan
);

   item_type   in_item;
   item_type   item;
   logic       fire;
   logic       can_load;
   result_type result;
   result_type out_data;
   csr_wr_type csr_wr;

   assign in_item.cmd   = req_chan.cmd;
   assign in_item.value = req_chan.value;

   assign csr_chan.ready = 1'b1;
   assign csr_wr.wr      = csr_chan.valid;
   assign csr_wr.index   = csr_chan.index;
   assign csr_wr.data    = csr_chan.data;

   dds_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (in_item),
      .down_ready (can_load),
      .fire       (fire),
      .item       (item)
   );

   dds_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   dds_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (result),
      .can_load  (can_load),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.drive_up        = out_data.drive_up;
   assign rsp_chan.drive_down      = out_data.drive_down;
   assign rsp_chan.led             = out_data.led;
   assign rsp_chan.direction       = out_data.direction;
   assign rsp_chan.height          = out_data.height;
   assign rsp_chan.upper_limit_out = out_data.upper_limit_out;
   assign rsp_chan.lower_limit_out = out_data.lower_limit_out;
   assign rsp_chan.limit_update    = out_data.limit_update;
   assign rsp_chan.stop_cause      = out_data.stop_cause;

endmodule

>>> rtl/dds_checker.sv
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks on the result channel of the desk drive supervisor.
// ----------------------------------------------------------------------------
module dds_checker
   import dds_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       drive_up,
   input logic       drive_down,
   input logic       led,
   input logic [1:0] direction,
   input logic [7:0] height,
   input logic [1:0] stop_cause
);

   // both motor lines are never on together
   a_motor_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(drive_up && drive_down))
      else $error("both motor lines asserted");

   // a stop leaves the desk at standstill
   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && stop_cause != STOP_NONE) |-> (direction == DIR_STOP))
      else $error("stop reported while still driving");

   // a stall always lights the indicator
   a_stall_led: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && stop_cause == STOP_STALL) |-> led)
      else $error("stall without led");

   // only framed heights within range are ever accepted
   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (height >= HEIGHT_MIN && height <= HEIGHT_MAX))
      else $error("height out of range");

   // a stalled result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind desk_drive_supervisor dds_checker u_dds_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .drive_up   (rsp_chan.drive_up),
   .drive_down (rsp_chan.drive_down),
   .led        (rsp_chan.led),
   .direction  (rsp_chan.direction),
   .height     (rsp_chan.height),
   .stop_cause (rsp_chan.stop_cause)
);

>>> sim/dds_drive_checker.sv
// ----------------------------------------------------------------------------
// dds_drive_checker
// Watches the request, result and register channels of the desk drive
// supervisor. It keeps its own copy of the supervisor state, predicts the
// result of every accepted event and compares each returned result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dds_drive_checker
   import dds_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dds_req_if   req_mon,
   dds_rsp_if   rsp_mon,
   dds_csr_if   csr_mon,
   output int   mismatches,
   output int   outstanding,
   output int   results_seen,
   output int   stall_stops,
   output int   limit_stops,
   output int   limit_writes
);
   timeunit 1ns;
   timeprecision 1ps;

   // timing registers
   logic [15:0] cfg_startup;
   logic [15:0] cfg_interval;
   logic [15:0] cfg_dclick;

   // predicted supervisor state
   logic [7:0]  win_prev;
   logic [7:0]  win_last;
   logic [7:0]  cur_height;
   logic [1:0]  moving;
   logic        armed;
   logic [31:0] ms_count;
   logic [31:0] drive_t0;
   logic [31:0] check_t0;
   logic [7:0]  ref_height;
   logic        up_pressed;
   logic        dn_pressed;
   logic [31:0] last_release_ms;
   logic [7:0]  lim_hi;
   logic [7:0]  lim_lo;
   logic        led_on;

   result_type  predicted_results[$];

   function automatic result_type model_event(input item_type ev);
      result_type res;
      logic       level;
      logic       self_held;
      logic       other_held;
      logic [1:0] btn_dir;
      logic [1:0] upd;
      logic [1:0] cause;
      int         h;
      int         delta;
      int         mid;
      upd        = UPD_NONE;
      cause      = STOP_NONE;
      btn_dir    = DIR_STOP;
      self_held  = 1'b0;
      other_held = 1'b0;
      case (ev.cmd)
         CMD_BYTE: begin
            if (win_prev == 8'd1 && win_last == 8'd0 &&
                ev.value >= HEIGHT_MIN && ev.value <= HEIGHT_MAX)
               cur_height = ev.value;
            win_prev = win_last;
            win_last = ev.value;
         end
         CMD_TICK: ms_count = ms_count + 32'd1;
         default: begin
            // button lines are ignored while the motor runs
            if (moving == DIR_STOP) begin
               level = (ev.value != 8'd0);
               if (ev.cmd == CMD_UP) begin
                  self_held  = up_pressed;
                  other_held = dn_pressed;
                  btn_dir    = DIR_UP;
               end else begin
                  self_held  = dn_pressed;
                  other_held = up_pressed;
                  btn_dir    = DIR_DOWN;
               end
               if (level && !self_held) begin
                  self_held = 1'b1;
                  led_on    = 1'b0;
                  if (other_held) begin
                     // store into whichever limit is nearer
                     mid = (int'(lim_hi) + int'(lim_lo)) / 2;
                     if (int'(cur_height) >= mid) begin
                        lim_hi = cur_height;
                        upd    = UPD_UPPER;
                     end else begin
                        lim_lo = cur_height;
                        upd    = UPD_LOWER;
                     end
                     self_held = 1'b0;
                  end
               end else if (!level && self_held) begin
                  self_held = 1'b0;
                  if (ms_count - last_release_ms < 32'(cfg_dclick))
                     moving = btn_dir;
                  else
                     last_release_ms = ms_count;
               end
               if (ev.cmd == CMD_UP)
                  up_pressed = self_held;
               else
                  dn_pressed = self_held;
            end
         end
      endcase

      h = int'(cur_height);
      if (moving == DIR_UP && h >= int'(lim_hi) - 1) begin
         moving = DIR_STOP;
         armed  = 1'b0;
         cause  = STOP_LIMIT;
      end else if (moving == DIR_DOWN && h <= int'(lim_lo) + 1) begin
         moving = DIR_STOP;
         armed  = 1'b0;
         cause  = STOP_LIMIT;
      end else if (moving != DIR_STOP) begin
         if (!armed) begin
            drive_t0   = ms_count;
            armed      = 1'b1;
            ref_height = (moving == DIR_DOWN) ? HEIGHT_MAX : 8'd0;
         end
         // check timer keeps running across drives
         if (ms_count - drive_t0 >= 32'(cfg_startup) &&
             ms_count - check_t0 >= 32'(cfg_interval)) begin
            delta      = h - int'(ref_height);
            check_t0   = ms_count;
            ref_height = cur_height;
            if ((delta >= 0 && moving == DIR_DOWN) || (delta <= 0 && moving == DIR_UP)) begin
               led_on = 1'b1;
               moving = DIR_STOP;
               armed  = 1'b0;
               cause  = STOP_STALL;
            end
         end
      end

      res.drive_up        = (moving == DIR_UP);
      res.drive_down      = (moving == DIR_DOWN);
      res.led             = led_on;
      res.direction       = moving;
      res.height          = cur_height;
      res.upper_limit_out = lim_hi;
      res.lower_limit_out = lim_lo;
      res.limit_update    = upd;
      res.stop_cause      = cause;
      return res;
   endfunction

   task automatic check_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("  result %0d: %s expected %0d, got %0d",
                     results_seen, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      item_type   ev;
      result_type want;
      result_type got;
      if (reset) begin
         cfg_startup     = STARTUP_DELAY_RST;
         cfg_interval    = CHECK_INTERVAL_RST;
         cfg_dclick      = DOUBLE_CLICK_RST;
         win_prev        = 8'd0;
         win_last        = 8'd0;
         cur_height      = HEIGHT_RST;
         moving          = DIR_STOP;
         armed           = 1'b0;
         ms_count        = 32'd0;
         drive_t0        = 32'd0;
         check_t0        = 32'd0;
         ref_height      = 8'd0;
         up_pressed      = 1'b0;
         dn_pressed      = 1'b0;
         last_release_ms = 32'd0;
         lim_hi          = UPPER_RST;
         lim_lo          = LOWER_RST;
         led_on          = 1'b0;
         predicted_results.delete();
         mismatches      = 0;
         results_seen    = 0;
         stall_stops     = 0;
         limit_stops     = 0;
         limit_writes    = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_STARTUP_DELAY:  cfg_startup  = csr_mon.data;
               CSR_CHECK_INTERVAL: cfg_interval = csr_mon.data;
               CSR_DOUBLE_CLICK:   cfg_dclick   = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            ev.cmd   = req_mon.cmd;
            ev.value = req_mon.value;
            predicted_results.push_back(model_event(ev));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.drive_up        = rsp_mon.drive_up;
            got.drive_down      = rsp_mon.drive_down;
            got.led             = rsp_mon.led;
            got.direction       = rsp_mon.direction;
            got.height          = rsp_mon.height;
            got.upper_limit_out = rsp_mon.upper_limit_out;
            got.lower_limit_out = rsp_mon.lower_limit_out;
            got.limit_update    = rsp_mon.limit_update;
            got.stop_cause      = rsp_mon.stop_cause;
            results_seen++;
            if (predicted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("  result %0d arrived with no event pending", results_seen);
            end else begin
               want = predicted_results.pop_front();
               check_field("drive_up", want.drive_up, got.drive_up);
               check_field("drive_down", want.drive_down, got.drive_down);
               check_field("led", want.led, got.led);
               check_field("direction", want.direction, got.direction);
               check_field("height", want.height, got.height);
               check_field("upper_limit_out", want.upper_limit_out, got.upper_limit_out);
               check_field("lower_limit_out", want.lower_limit_out, got.lower_limit_out);
               check_field("limit_update", want.limit_update, got.limit_update);
               check_field("stop_cause", want.stop_cause, got.stop_cause);
               if (want.stop_cause == STOP_STALL) stall_stops++;
               if (want.stop_cause == STOP_LIMIT) limit_stops++;
               if (want.limit_update != UPD_NONE) limit_writes++;
            end
         end
      end
      outstanding <= predicted_results.size();
   end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the desk drive supervisor. A directed opening
// covers height frames at and beyond the valid range, repeated levels, a
// release inside the double-click window, ignored buttons while driving,
// limit storing and a limit stop. Then several timing settings, extremes
// included, are run with random frames, double clicks, drive ramps, limit
// stores, tick bursts and noise, under random idling on both sides and a
// long result hold-off.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dds_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 145;
   localparam int NUM_PHASES  = 7;
   localparam int HOLD_CYCLES = 150;

   logic clock;
   logic reset;

   dds_req_if req_chan();
   dds_rsp_if rsp_chan();
   dds_csr_if csr_chan();

   int mismatches;
   int outstanding;
   int results_seen;
   int stall_stops;
   int limit_stops;
   int limit_writes;
   int cycle_count = 0;
   int items_sent;
   int track_h;
   bit send_idle;
   bit rsp_idle;
   bit hold_req;

   desk_drive_supervisor DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   dds_drive_checker drive_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_mon      (csr_chan),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .stall_stops  (stall_stops),
      .limit_stops  (limit_stops),
      .limit_writes (limit_writes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[desk_drive_supervisor] ERROR");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side: random ready, or a long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            n = HOLD_CYCLES;
         end else if (!rsp_idle || $urandom_range(0, 99) < 65) begin
            rsp_chan.ready <= 1'b1;
            n = $urandom_range(1, 10);
         end else begin
            rsp_chan.ready <= 1'b0;
            n = idle_len() + 1;
         end
         repeat (n) @(posedge clock);
      end
   end

   task automatic send(input logic [1:0] cmd, input logic [7:0] value);
      int gap;
      gap = send_idle ? idle_len() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic tick(input int n);
      repeat (n) send(CMD_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic press(input logic [1:0] btn);
      send(btn, 8'($urandom_range(1, 255)));
   endtask

   task automatic lift(input logic [1:0] btn);
      send(btn, 8'd0);
   endtask

   task automatic frame(input logic [7:0] h);
      send(CMD_BYTE, 8'd1);
      send(CMD_BYTE, 8'd0);
      send(CMD_BYTE, h);
      if (h >= HEIGHT_MIN && h <= HEIGHT_MAX) track_h = h;
   endtask

   task automatic double_click(input logic [1:0] btn);
      press(btn);
      tick($urandom_range(0, 3));
      lift(btn);
      tick($urandom_range(0, 3));
      press(btn);
      tick($urandom_range(0, 2));
      lift(btn);
   endtask

   // start a drive and feed a height ramp, stalling now and then
   task automatic drive_run();
      logic [1:0] btn;
      int         steps;
      int         i;
      int         h;
      int         delta;
      btn = ($urandom_range(0, 1) != 0) ? CMD_UP : CMD_DOWN;
      double_click(btn);
      steps = $urandom_range(3, 18);
      h = track_h;
      for (i = 0; i < steps; i++) begin
         tick($urandom_range(0, 4));
         if ($urandom_range(0, 99) < 70) begin
            delta = $urandom_range(1, 3);
            h = (btn == CMD_UP) ? h + delta : h - delta;
            if (h > HEIGHT_MAX) h = HEIGHT_MAX;
            if (h < HEIGHT_MIN) h = HEIGHT_MIN;
         end
         frame(8'(h));
         if ($urandom_range(0, 9) == 0) begin
            press((btn == CMD_UP) ? CMD_DOWN : CMD_UP);
            lift((btn == CMD_UP) ? CMD_DOWN : CMD_UP);
         end
      end
   endtask

   task automatic random_episode();
      int         r;
      int         n;
      logic [1:0] a;
      logic [1:0] b;
      r = $urandom_range(0, 99);
      a = ($urandom_range(0, 1) != 0) ? CMD_UP : CMD_DOWN;
      b = (a == CMD_UP) ? CMD_DOWN : CMD_UP;
      if (r < 25) begin
         if ($urandom_range(0, 99) < 85)
            frame(8'($urandom_range(HEIGHT_MIN, HEIGHT_MAX)));
         else
            frame(8'($urandom_range(0, 255)));
      end else if (r < 43) begin
         double_click(a);
      end else if (r < 55) begin
         // both buttons: store a limit
         press(a);
         tick($urandom_range(0, 2));
         press(b);
         tick($urandom_range(0, 2));
         lift(a);
         if ($urandom_range(0, 1) != 0) lift(b);
      end else if (r < 80) begin
         drive_run();
      end else if (r < 95) begin
         n = $urandom_range(1, 6);
         repeat (n) send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
         tick($urandom_range(5, 40));
      end
   endtask

   // lets every pending result come back, then the block is idle
   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // valid stays high across back-to-back writes
   task automatic write_csr(input logic [7:0] idx, input logic [15:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic load_timing(input logic [15:0] startup, input logic [15:0] interval,
                              input logic [15:0] dclick);
      wait_all_results();
      write_csr(CSR_STARTUP_DELAY, startup);
      write_csr(CSR_CHECK_INTERVAL, interval);
      write_csr(CSR_DOUBLE_CLICK, dclick);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int ph;
      int start_count;
      bit held_done;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd   <= CMD_BYTE;
      req_chan.value <= 8'd0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_STARTUP_DELAY;
      csr_chan.data  <= 16'd0;
      send_idle  = 1'b1;
      rsp_idle   = 1'b1;
      hold_req   = 1'b0;
      items_sent = 0;
      track_h    = HEIGHT_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
               send(CMD_TICK, 8'hFF);         // tick value is don't-care
               frame(HEIGHT_MAX);
               frame(HEIGHT_MIN);
               frame(8'd131);                 // out of range, rejected
               frame(8'd64);
               frame(8'd100);
               send(CMD_UP, 8'h80);
               send(CMD_UP, 8'h01);           // same level again
               lift(CMD_UP);                  // release close to reset: drives up
               send(CMD_DOWN, 8'hFF);         // ignored while driving
               frame(8'd114);                 // one below the upper limit: stop
               lift(CMD_DOWN);                // low on a released button
               send(CMD_UP, 8'd1);
               send(CMD_DOWN, 8'd1);          // both held: upper limit rewritten
               lift(CMD_UP);
            end
            1: load_timing(16'd0, 16'd1, 16'hFFFF);
            2: load_timing(16'hFFFF, 16'hFFFF, 16'd1);
            3: load_timing(16'd3, 16'd2, 16'd15);
            default: load_timing(16'($urandom_range(0, 40)), 16'($urandom_range(1, 20)),
                                 16'($urandom_range(2, 80)));
         endcase
         send_idle   = (ph != 1);
         rsp_idle    = (ph != 1) && (ph != 4);
         held_done   = 1'b0;
         start_count = items_sent;
         while (items_sent - start_count < PHASE_ITEMS) begin
            // long result hold-off while events keep coming
            if ((ph == 3 || ph == 5) && !held_done && items_sent - start_count >= 40) begin
               hold_req  = 1'b1;
               held_done = 1'b1;
            end
            random_episode();
         end
      end

      wait_all_results();
      repeat (5) @(posedge clock);
      $display("Ran %0d events over %0d timing settings, %0d results checked.",
               items_sent, NUM_PHASES, results_seen);
      $display("Stops at a limit: %0d, stall stops: %0d, limit stores: %0d, mismatches: %0d.",
               limit_stops, stall_stops, limit_writes, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[desk_drive_supervisor] OK");
      end else begin
         $display("[desk_drive_supervisor] ERROR");
      end
      $finish;
   end

endmodule
